FILE: hw/rtl/ogrm_pkg.sv
// ----------------------------------------------------------------------------
// ogrm_pkg
// Shared types and constants of the occupancy grid region map: grid geometry,
// item kinds, register indexes and the layout of one grid cell.
// ----------------------------------------------------------------------------
package ogrm_pkg;

	localparam int GRID_SIZE     = 256;
	localparam int COORD_W       = 8;
	localparam int SIDE_W        = COORD_W + 1;
	localparam int ADDR_W        = 2 * COORD_W;
	localparam int MAX_RADIUS    = 15;
	localparam int RADIUS_W      = 4;
	localparam int OWNER_ID_BITS = 16;
	localparam int ID_W          = 16;
	localparam int HEIGHT_W      = 16;
	localparam int KIND_W        = 3;
	localparam int CFG_INDEX_W   = 4;
	localparam int CFG_DATA_W    = 16;

	localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ADD       = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_Q_BLOCKED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_Q_WET     = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] CFG_WATER_LEVEL = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SIZE    = 4'd1;

	typedef struct packed {
		logic                     wet;
		logic                     used;
		logic [OWNER_ID_BITS-1:0] owner;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

endpackage

FILE: hw/rtl/occupancy_grid_region_map.sv
// ----------------------------------------------------------------------------
// occupancy_grid_region_map
// Square occupancy grid kept in one cell RAM. Load items write one cell,
// add and remove items edit a clamped square region, queries scan it.
//
// Use: an item is transferred when start is high and busy is low. Each item
// produces exactly one result: done is high for one cycle with hit and
// map_ready on the result ports. The receiver cannot stall; results are
// taken in the cycle they are shown.
// Configuration: cfg_valid/cfg_ready transfers cfg_data to register
// cfg_index (0 water level, 1 map size); cfg_ready is always high. Write
// registers only while the block is idle.
// Flow: load items, and add, remove and query items that find no valid
// map or an empty clamped region, give done in the cycle after the
// transfer, busy stays low, so one such item per cycle. Region items scan
// (w x h) cells of the clamped region, one RAM read per cycle, with edits
// written back the cycle after the read; the single read port of the
// cell RAM sets this rate. Busy is high until done, registered in S_DRAIN.
// Reset: clears the control state, map_ready, water level (0) and map size
// (256). The cell RAM is not cleared; cells must be loaded before use.
// ----------------------------------------------------------------------------
module occupancy_grid_region_map
	import ogrm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [KIND_W-1:0]      kind,
	input  logic [COORD_W-1:0]     center_x,
	input  logic [COORD_W-1:0]     center_y,
	input  logic [RADIUS_W-1:0]    radius,
	input  logic [ID_W-1:0]        object_id,
	input  logic [HEIGHT_W-1:0]    height,
	output logic                   done,
	output logic                   hit,
	output logic                   map_ready,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN
	} state_t;

	state_t               state_q;
	logic [HEIGHT_W-1:0]  water_level_q;
	logic [SIDE_W-1:0]    map_size_q;
	logic                 map_valid_q;
	logic                 done_q;
	logic                 hit_q;
	logic                 map_ready_q;
	logic [KIND_W-1:0]    op_q;
	logic [COORD_W-1:0]   x_q;
	logic [COORD_W-1:0]   y_q;
	logic [COORD_W-1:0]   x0_q;
	logic [COORD_W-1:0]   x1_q;
	logic [COORD_W-1:0]   y1_q;
	logic [OWNER_ID_BITS-1:0] owner_q;
	logic                 hit_acc_q;
	logic                 vld_s1;
	logic [ADDR_W-1:0]    addr_s1;

	logic [SIDE_W-1:0]    side;
	logic [COORD_W-1:0]   side_m1;
	logic [RADIUS_W-1:0]  r_sat;
	logic [COORD_W-1:0]   lo_x, lo_y, hi_x, hi_y;
	logic [SIDE_W-1:0]    top_x, top_y;
	logic                 region_empty;
	logic                 accept;
	logic                 is_edit, is_query;
	logic                 load_in_grid, load_wet, load_corner;
	logic                 op_edit, op_query;
	logic                 match_s1;
	logic                 scan_last;
	cell_t                rd_cell, wr_cell;
	logic                 ram_we, ram_re;
	logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
	logic [CELL_W-1:0]    ram_rdata;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign hit       = hit_q;
	assign map_ready = map_ready_q;

	// side in use, clamped to 1 .. GRID_SIZE
	always_comb begin
		if (map_size_q == '0) begin
			side = SIDE_W'(1);
		end else if (map_size_q > SIDE_W'(GRID_SIZE)) begin
			side = SIDE_W'(GRID_SIZE);
		end else begin
			side = map_size_q;
		end
		side_m1 = COORD_W'(side - SIDE_W'(1));
	end

	// clamped region of the incoming item
	always_comb begin
		r_sat = (radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius;
		top_x = {1'b0, center_x} + SIDE_W'(r_sat);
		top_y = {1'b0, center_y} + SIDE_W'(r_sat);
		lo_x  = (center_x >= COORD_W'(r_sat)) ? center_x - COORD_W'(r_sat) : '0;
		lo_y  = (center_y >= COORD_W'(r_sat)) ? center_y - COORD_W'(r_sat) : '0;
		hi_x  = (top_x < {1'b0, side_m1}) ? top_x[COORD_W-1:0] : side_m1;
		hi_y  = (top_y < {1'b0, side_m1}) ? top_y[COORD_W-1:0] : side_m1;
		region_empty = (lo_x > hi_x) || (lo_y > hi_y);
		is_edit  = kind inside {KIND_ADD, KIND_REMOVE};
		is_query = kind inside {KIND_Q_BLOCKED, KIND_Q_WET};
		load_in_grid = ({1'b0, center_x} < side) && ({1'b0, center_y} < side);
		load_wet     = (water_level_q != '0) && (height <= water_level_q);
		load_corner  = (center_x == side_m1) && (center_y == side_m1);
	end

	// stage 1: data of the cell read last cycle
	always_comb begin
		rd_cell   = cell_t'(ram_rdata);
		op_edit   = (op_q == KIND_ADD) || (op_q == KIND_REMOVE);
		op_query  = (op_q == KIND_Q_BLOCKED) || (op_q == KIND_Q_WET);
		match_s1  = (op_q == KIND_Q_BLOCKED) ? (rd_cell.wet || rd_cell.used) : rd_cell.wet;
		scan_last = (x_q == x1_q) && (y_q == y1_q);
	end

	// ram port control
	always_comb begin
		ram_re    = (state_q == S_SCAN);
		ram_raddr = {y_q, x_q};
		if (state_q == S_IDLE) begin
			ram_we        = accept && (kind == KIND_LOAD) && load_in_grid;
			ram_waddr     = {center_y, center_x};
			wr_cell.wet   = load_wet;
			wr_cell.used  = 1'b0;
			wr_cell.owner = '0;
		end else begin
			ram_we        = vld_s1 && op_edit;
			ram_waddr     = addr_s1;
			wr_cell.wet   = rd_cell.wet;
			wr_cell.used  = (op_q == KIND_ADD);
			wr_cell.owner = (op_q == KIND_ADD) ? owner_q : '0;
		end
	end

	ogrm_cell_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (CELL_W)
	) u_cell_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (CELL_W'(wr_cell)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_level_q <= '0;
			map_size_q    <= SIDE_W'(GRID_SIZE);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WATER_LEVEL: water_level_q <= cfg_data;
				CFG_MAP_SIZE:    map_size_q    <= cfg_data[SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 address
	always_ff @(posedge clk) begin
		addr_s1 <= ram_raddr;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			map_valid_q <= 1'b0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			map_ready_q <= 1'b0;
			op_q        <= KIND_LOAD;
			x_q         <= '0;
			y_q         <= '0;
			x0_q        <= '0;
			x1_q        <= '0;
			y1_q        <= '0;
			owner_q     <= '0;
			hit_acc_q   <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q      <= kind;
						x_q       <= lo_x;
						y_q       <= lo_y;
						x0_q      <= lo_x;
						x1_q      <= hi_x;
						y1_q      <= hi_y;
						owner_q   <= object_id[OWNER_ID_BITS-1:0];
						hit_acc_q <= 1'b0;
						if ((is_edit || is_query) && map_valid_q && !region_empty) begin
							state_q <= S_SCAN;
							done_q  <= 1'b0;
						end else begin
							done_q      <= 1'b1;
							hit_q       <= is_query && !map_valid_q;
							map_ready_q <= map_valid_q ||
								((kind == KIND_LOAD) && load_in_grid && load_corner);
							if ((kind == KIND_LOAD) && load_in_grid && load_corner) begin
								map_valid_q <= 1'b1;
							end
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				S_SCAN: begin
					done_q <= 1'b0;
					if (vld_s1 && op_query && match_s1) begin
						hit_acc_q <= 1'b1;
					end
					if (x_q == x1_q) begin
						x_q <= x0_q;
						y_q <= y_q + COORD_W'(1);
					end else begin
						x_q <= x_q + COORD_W'(1);
					end
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					done_q      <= 1'b1;
					hit_q       <= hit_acc_q || (op_query && match_s1);
					map_ready_q <= map_valid_q;
					state_q     <= S_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// assertions
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without a transferred item");

	a_no_same_cell_rw: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("read and write of the same cell in one cycle");

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ((state_q == S_SCAN) || (state_q == S_DRAIN)))
		else $error("stage 1 valid outside a region scan");

	a_map_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(map_valid_q))
		else $error("map valid cleared without reset");

endmodule

FILE: hw/rtl/ogrm_cell_ram.sv
// ----------------------------------------------------------------------------
// ogrm_cell_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. No reset of the contents.
// ----------------------------------------------------------------------------
module ogrm_cell_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 18
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
